/* hdl/ots_pkg.sv */
// shared types and constants for the oscillator trim search
`timescale 1ns / 1ps
`default_nettype none

package ots_pkg;

    localparam int COUNT_BITS   = 20;
    localparam int TRIM_BITS    = 7;
    localparam int CFG_IDX_BITS = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_COUNT = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_TRIM = 1'd1;

    // item function codes
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_MEASURE = 1'b1;

    localparam logic [COUNT_BITS-1:0] TARGET_RESET = COUNT_BITS'(1808);
    localparam logic [TRIM_BITS-1:0]  TRIM_RESET   = TRIM_BITS'(1) << (TRIM_BITS - 1);
    localparam logic [TRIM_BITS-1:0]  TRIM_MAX     = {TRIM_BITS{1'b1}};

    typedef struct packed {
        logic [TRIM_BITS-1:0]  trim_now;
        logic [TRIM_BITS-1:0]  trim_before;
        logic [COUNT_BITS-1:0] count_before;
        logic                  saw_low;
        logic                  saw_high;
        logic                  finished;
    } search_state_t;

    typedef struct packed {
        logic [TRIM_BITS-1:0] trim;
        logic                 done;
        logic                 reverted;
    } search_result_t;

endpackage

`default_nettype wire

/* hdl/ots_step.sv */
// one search step: next search state and result for one item
`timescale 1ns / 1ps
`default_nettype none

module ots_step (
    input  wire logic                           func,
    input  wire logic [ots_pkg::COUNT_BITS-1:0] measured_count,
    input  wire logic [ots_pkg::COUNT_BITS-1:0] target_count,
    input  wire logic [ots_pkg::TRIM_BITS-1:0]  initial_trim,
    input  wire ots_pkg::search_state_t         state_cur,
    output ots_pkg::search_state_t              state_nxt,
    output ots_pkg::search_result_t             result
);
    import ots_pkg::*;

    logic                  cnt_low;
    logic                  cnt_high;
    logic [COUNT_BITS-1:0] dist_cur;
    logic [COUNT_BITS-1:0] dist_prev;
    logic                  prev_closer;
    logic                  rev;

    assign cnt_low  = measured_count < target_count;
    assign cnt_high = measured_count > target_count;

    // absolute distances of this count and the previous count from target
    assign dist_cur  = cnt_high ? (measured_count - target_count)
                                : (target_count - measured_count);
    assign dist_prev = (state_cur.count_before > target_count)
                     ? (state_cur.count_before - target_count)
                     : (target_count - state_cur.count_before);
    assign prev_closer = dist_cur > dist_prev;

    always_comb
    begin
        state_nxt = state_cur;
        rev       = 1'b0;
        if (func == FUNC_START)
        begin
            state_nxt.trim_now     = initial_trim;
            state_nxt.trim_before  = '0;
            state_nxt.count_before = '0;
            state_nxt.saw_low      = 1'b0;
            state_nxt.saw_high     = 1'b0;
            state_nxt.finished     = 1'b0;
        end
        else if (!state_cur.finished)
        begin
            if (cnt_low)
            begin
                if (state_cur.saw_high)
                begin
                    // crossed from high to low: keep the closer trim
                    if (prev_closer)
                    begin
                        state_nxt.trim_now = state_cur.trim_before;
                        rev                = 1'b1;
                    end
                    state_nxt.finished = 1'b1;
                end
                else if (dist_cur == COUNT_BITS'(1))
                begin
                    state_nxt.finished = 1'b1;
                end
                else
                begin
                    state_nxt.trim_before = state_cur.trim_now;
                    if (state_cur.trim_now != TRIM_MAX)
                    begin
                        state_nxt.trim_now = state_cur.trim_now + TRIM_BITS'(1);
                    end
                    state_nxt.saw_low      = 1'b1;
                    state_nxt.count_before = measured_count;
                end
            end
            else if (cnt_high)
            begin
                if (state_cur.saw_low)
                begin
                    // crossed from low to high: keep the closer trim
                    if (prev_closer)
                    begin
                        state_nxt.trim_now = state_cur.trim_before;
                        rev                = 1'b1;
                    end
                    state_nxt.finished = 1'b1;
                end
                else if (dist_cur == COUNT_BITS'(1))
                begin
                    state_nxt.finished = 1'b1;
                end
                else
                begin
                    state_nxt.trim_before = state_cur.trim_now;
                    if (state_cur.trim_now != '0)
                    begin
                        state_nxt.trim_now = state_cur.trim_now - TRIM_BITS'(1);
                    end
                    state_nxt.saw_high     = 1'b1;
                    state_nxt.count_before = measured_count;
                end
            end
            else
            begin
                state_nxt.finished = 1'b1;
            end
        end
    end

    assign result.trim     = state_nxt.trim_now;
    assign result.done     = state_nxt.finished;
    assign result.reverted = rev;

endmodule

`default_nettype wire

/* hdl/oscillator_trim_search.sv */
// top level of the rc oscillator linear trim search
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                       direction
// -------   -------------------------------------------   ---------
// in        in_valid, in_ready, func, measured_count      into block
// out       out_valid, out_ready, trim_out, done_res,     out of block
//           reverted
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data     into block
//
// an item is first held in the input register, then the
// search step updates the state and loads the result register
// one item per cycle sustained while out_ready is high; the search state loop closes through the state register
// reset clears the search state to a fresh calibration at the reset trim
// a stalled result register holds the input stage; cfg is always ready

module oscillator_trim_search (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // item input
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             func,
    input  wire logic [ots_pkg::COUNT_BITS-1:0]   measured_count,
    // result output
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [ots_pkg::TRIM_BITS-1:0]         trim_out,
    output logic                                  done_res,
    output logic                                  reverted,
    // register writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ots_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ots_pkg::COUNT_BITS-1:0]   cfg_data
);
    import ots_pkg::*;

    // configuration registers
    logic [COUNT_BITS-1:0] target_count_reg;
    logic [TRIM_BITS-1:0]  initial_trim_reg;

    // input stage
    logic                  in_vld_reg;
    logic                  func_reg;
    logic [COUNT_BITS-1:0] count_reg;

    // search state and result stage
    search_state_t         state_reg;
    search_state_t         state_next;
    search_result_t        result_next;
    search_result_t        result_reg;
    logic                  out_vld_reg;

    logic                  advance;

    // the input item moves on whenever the result register is free or draining
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_count_reg <= TARGET_RESET;
            initial_trim_reg <= TRIM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TARGET_COUNT: target_count_reg <= cfg_data;
                REG_INITIAL_TRIM: initial_trim_reg <= cfg_data[TRIM_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            count_reg <= measured_count;
        end
    end

    ots_step u_step (
        .func           (func_reg),
        .measured_count (count_reg),
        .target_count   (target_count_reg),
        .initial_trim   (initial_trim_reg),
        .state_cur      (state_reg),
        .state_nxt      (state_next),
        .result         (result_next)
    );

    // search state commits when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.trim_now     <= TRIM_RESET;
            state_reg.trim_before  <= '0;
            state_reg.count_before <= '0;
            state_reg.saw_low      <= 1'b0;
            state_reg.saw_high     <= 1'b0;
            state_reg.finished     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign trim_out  = result_reg.trim;
    assign done_res  = result_reg.done;
    assign reverted  = result_reg.reverted;

endmodule

`default_nettype wire
